/* hw/rtl/olar_pkg.sv */
// Shared types and sizes for the ordered list block.
// No dependencies; used by the top level and its checker.
package olar_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic signed [31:0] value;
    logic               is_last;
  } in_t;

  typedef struct packed {
    logic [30:0] entry_value;
    logic        last_entry;
    logic        overflow_seen;
  } out_t;

endpackage

/* hw/rtl/ordered_list_append_remove_at.sv */
// Ordered list with append, positional remove and drain on the last item.
// Depends on olar_pkg for sizes and the transfer structs.
//
// Append or ignored item: busy stays low unless the item is the last. Removal at
// position p of n entries runs a shift: the store, with one write port and one
// registered read port, moves one entry a cycle, then the shift closes.
// Drain reads the entries in order; results come one per cycle with no gaps,
// each behind its registered read, and cannot be stalled.
// Reset (synchronous, rst_n low) empties the list and clears the overflow flag.
module ordered_list_append_remove_at (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  olar_pkg::in_t in_data,
  output logic          out_valid,
  output olar_pkg::out_t out_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [olar_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [olar_pkg::CNT_W-1:0] ptr_r, ptr_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       drain_r, drain_nxt;
  logic                       rvalid_r;
  logic [30:0]                rdata_r;

  logic [30:0] mem [olar_pkg::CAPACITY];

  logic                       accept;
  logic                       rd_en;
  logic [olar_pkg::IDX_W-1:0] rd_addr;
  logic                       wr_en;
  logic [olar_pkg::IDX_W-1:0] wr_addr;
  logic [30:0]                wr_data;
  logic [31:0]                mag;
  logic                       is_remove;
  logic [olar_pkg::CNT_W-1:0] wr_ptr;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign mag       = 32'(-in_data.value);
  assign is_remove = in_data.value[31] && (in_data.value[30:0] != 31'd0);
  // the read issued on the previous advance lands one slot below its source
  assign wr_ptr    = ptr_r - olar_pkg::CNT_W'(2);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    ovf_nxt   = ovf_r;
    drain_nxt = drain_r;
    rd_en     = 1'b0;
    rd_addr   = ptr_r[olar_pkg::IDX_W-1:0];
    wr_en     = 1'b0;
    wr_addr   = count_r[olar_pkg::IDX_W-1:0];
    wr_data   = in_data.value[30:0];
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          drain_nxt = in_data.is_last;
          ptr_nxt   = '0;
          if (in_data.is_last) begin
            state_nxt = ST_DRAIN;
          end
          if (!in_data.value[31]) begin
            if (count_r < olar_pkg::CNT_W'(olar_pkg::CAPACITY)) begin
              wr_en     = 1'b1;
              count_nxt = count_r + olar_pkg::CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (is_remove && (mag < 32'(count_r))) begin
            ptr_nxt   = mag[olar_pkg::CNT_W-1:0] + olar_pkg::CNT_W'(1);
            state_nxt = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        rd_en   = (ptr_r < count_r);
        wr_en   = rvalid_r;
        wr_addr = wr_ptr[olar_pkg::IDX_W-1:0];
        wr_data = rdata_r;
        if (rd_en) begin
          ptr_nxt = ptr_r + olar_pkg::CNT_W'(1);
        end else if (!rvalid_r) begin
          count_nxt = count_r - olar_pkg::CNT_W'(1);
          ptr_nxt   = '0;
          state_nxt = drain_r ? ST_DRAIN : ST_IDLE;
        end
      end
      ST_DRAIN: begin
        rd_en = (ptr_r < count_r);
        if (rd_en) begin
          ptr_nxt = ptr_r + olar_pkg::CNT_W'(1);
        end else if (!rvalid_r) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          drain_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      ptr_r    <= '0;
      ovf_r    <= 1'b0;
      drain_r  <= 1'b0;
      rvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ptr_r    <= ptr_nxt;
      ovf_r    <= ovf_nxt;
      drain_r  <= drain_nxt;
      rvalid_r <= rd_en;
    end
  end

  // entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign out_valid              = (state_r == ST_DRAIN) && rvalid_r;
  assign out_data.entry_value   = rdata_r;
  assign out_data.last_entry    = (ptr_r == count_r);
  assign out_data.overflow_seen = ovf_r;

endmodule

/* hw/rtl/olar_checker.sv */
// Port-level checks for the ordered list block, bound to its top level.
// Depends on olar_pkg for the transfer structs.
module olar_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input olar_pkg::in_t  in_data,
  input logic           out_valid,
  input olar_pkg::out_t out_data
);

  a_out_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result transfer while not busy");

  a_append_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_data.is_last && !in_data.value[31]) |=> !busy)
    else $error("plain append left the block busy");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_entry) |=> !out_valid)
    else $error("result transfer after the final entry");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

endmodule

bind ordered_list_append_remove_at olar_checker u_olar_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
